@@ design/mtep_pkg.sv @@
`default_nettype none
// ============================================================================
// mtep_pkg: shared types and constants of the MIDI track event parser
// Status codes, parser phases, result word layout and the size-field helper.
// ============================================================================
package mtep_pkg;

    // Default width of the delta-time accumulator
    localparam int DELTA_BITS_DEF = 28;

    // Field widths of the words on both channels
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int CHAN_W  = 4;
    localparam int KEY_W   = 7;
    localparam int VALUE_W = 24;
    localparam int TICKS_W = 28;
    localparam int LEN_W   = 28;
    localparam int DATA_W  = 7;
    localparam int COUNT_W = 2;

    // Status and meta codes
    localparam logic [BYTE_W-1:0] ST_SYSEX  = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_ESCAPE = 8'hF7;
    localparam logic [BYTE_W-1:0] ST_META   = 8'hFF;
    localparam logic [BYTE_W-1:0] META_EOT  = 8'h2F;
    localparam logic [BYTE_W-1:0] META_TEMPO = 8'h51;

    // High nibble of channel status bytes
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_KEY_PRESS  = 4'hA;
    localparam logic [3:0] HI_CONTROL    = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    // Last tempo byte index and tempo payload size
    localparam logic [COUNT_W-1:0] TEMPO_LAST  = 2'd2;
    localparam logic [LEN_W-1:0]   TEMPO_BYTES = 28'd3;

    typedef enum logic [3:0] {
        PH_DELTA      = 4'd0,
        PH_STATUS     = 4'd1,
        PH_DATA1      = 4'd2,
        PH_DATA2      = 4'd3,
        PH_META_TYPE  = 4'd4,
        PH_META_LEN   = 4'd5,
        PH_TEMPO      = 4'd6,
        PH_SYSEX_LEN  = 4'd7,
        PH_SYSEX_PEEK = 4'd8,
        PH_SKIP       = 4'd9,
        PH_DONE       = 4'd10
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_OFF    = 4'd0,
        KIND_NOTE_ON     = 4'd1,
        KIND_KEY_PRESS   = 4'd2,
        KIND_CONTROL     = 4'd3,
        KIND_PROGRAM     = 4'd4,
        KIND_CHAN_PRESS  = 4'd5,
        KIND_BEND        = 4'd6,
        KIND_TEMPO       = 4'd7,
        KIND_END         = 4'd8,
        KIND_NO_RUNNING  = 4'd9,
        KIND_UNSUPPORTED = 4'd10
    } t_kind;

    // Input word
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              track_start;
    } t_byte_word;

    // Result word
    typedef struct packed {
        t_kind              event_kind;
        logic [CHAN_W-1:0]  channel;
        logic [KEY_W-1:0]   key_or_number;
        logic [VALUE_W-1:0] event_value;
        logic [TICKS_W-1:0] delta_ticks;
        logic               delta_saturated;
    } t_event;

    // Parser datapath state besides phase and delta
    typedef struct packed {
        logic [BYTE_W-1:0]  running;
        logic [BYTE_W-1:0]  cur_status;
        logic [BYTE_W-1:0]  meta_type;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   skip;
        logic [DATA_W-1:0]  first;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '0;

    // Shift one size byte into a length, saturating at all ones
    function automatic logic [LEN_W-1:0] add_length(input logic [LEN_W-1:0] len,
                                                    input logic [BYTE_W-1:0] b);
        if (|len[LEN_W-1 -: DATA_W]) begin
            return '1;
        end
        return {len[LEN_W-DATA_W-1:0], b[DATA_W-1:0]};
    endfunction

endpackage
`default_nettype wire

@@ design/mtep_if.sv @@
`default_nettype none
// ============================================================================
// mtep_if: channel interfaces of the MIDI track event parser
// Byte channel in, event channel out, each with valid/ready handshake.
// ============================================================================
interface mtep_byte_if;
    logic                       valid;
    logic                       ready;
    logic [mtep_pkg::BYTE_W-1:0] data_byte;
    logic                       track_start;

    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_event_if;
    logic                         valid;
    logic                         ready;
    logic [mtep_pkg::KIND_W-1:0]  event_kind;
    logic [mtep_pkg::CHAN_W-1:0]  channel;
    logic [mtep_pkg::KEY_W-1:0]   key_or_number;
    logic [mtep_pkg::VALUE_W-1:0] event_value;
    logic [mtep_pkg::TICKS_W-1:0] delta_ticks;
    logic                         delta_saturated;

    modport source (output valid, output event_kind, output channel, output key_or_number,
                    output event_value, output delta_ticks, output delta_saturated,
                    input ready);
    modport sink   (input valid, input event_kind, input channel, input key_or_number,
                    input event_value, input delta_ticks, input delta_saturated,
                    output ready);
endinterface
`default_nettype wire

@@ design/mtep_in_stage.sv @@
`default_nettype none
// ============================================================================
// mtep_in_stage: input register
// Captures one byte word and holds it until the parser consumes it.
// ============================================================================
module mtep_in_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mtep_byte_if.sink             i_byte,
    input  wire logic             i_take,
    output logic                  o_valid,
    output mtep_pkg::t_byte_word  o_word
);

    logic                 r_valid;
    mtep_pkg::t_byte_word r_word;
    logic                 w_load;

    // Accept when empty or when the held word leaves this cycle
    assign i_byte.ready = !r_valid || i_take;
    assign w_load       = i_byte.valid && i_byte.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word.data_byte   <= i_byte.data_byte;
            r_word.track_start <= i_byte.track_start;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

@@ design/mtep_parser.sv @@
`default_nettype none
// ============================================================================
// mtep_parser: track body parser state machine
// Decodes one byte per cycle when fired: delta time, status, data, meta and sysex
// framing, and forms at most one event word per byte.
// ============================================================================
module mtep_parser #(
    parameter int DELTA_BITS = mtep_pkg::DELTA_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire mtep_pkg::t_byte_word i_word,
    output logic                      o_emit,
    output mtep_pkg::t_event          o_event
);

    mtep_pkg::t_phase       r_phase, n_phase, c_phase;
    mtep_pkg::t_parse_state r_dp, n_dp, c_dp;
    logic [DELTA_BITS-1:0]  r_delta, n_delta, c_delta;
    logic                   r_clamped, n_clamped, c_clamped;

    logic [mtep_pkg::BYTE_W-1:0]  w_b;
    logic [mtep_pkg::DATA_W-1:0]  w_d;
    logic                         w_msb;
    logic [mtep_pkg::BYTE_W-1:0]  w_st;
    logic                         w_no_running;
    logic                         w_st_meta;
    logic                         w_st_sysex;
    logic                         w_st_chan;
    logic [mtep_pkg::BYTE_W-1:0]  w_d1_status;
    logic                         w_d1_single;
    logic [mtep_pkg::LEN_W-1:0]   w_len_next;
    logic [mtep_pkg::VALUE_W-1:0] w_tempo_val;
    logic                         w_tempo_last;
    logic                         w_surplus;
    logic                         w_skip_done;
    logic                         w_delta_sat;
    logic [DELTA_BITS-1:0]        w_delta_next;
    logic                         w_emit;
    mtep_pkg::t_event             w_event;

    // Apply a track start before anything else
    assign c_phase   = i_word.track_start ? mtep_pkg::PH_DELTA : r_phase;
    assign c_dp      = i_word.track_start ? mtep_pkg::PARSE_RESET : r_dp;
    assign c_delta   = i_word.track_start ? '0 : r_delta;
    assign c_clamped = i_word.track_start ? 1'b0 : r_clamped;

    // Byte and status decode
    assign w_b          = i_word.data_byte;
    assign w_d          = w_b[mtep_pkg::DATA_W-1:0];
    assign w_msb        = w_b[mtep_pkg::BYTE_W-1];
    assign w_st         = w_msb ? w_b : c_dp.running;
    assign w_no_running = !w_msb && (c_dp.running == '0);
    assign w_st_meta    = (w_st == mtep_pkg::ST_META);
    assign w_st_sysex   = w_msb && ((w_b == mtep_pkg::ST_SYSEX) || (w_b == mtep_pkg::ST_ESCAPE));
    assign w_st_chan    = (w_st[7:4] != mtep_pkg::HI_SYSTEM);
    assign w_d1_status  = (c_phase == mtep_pkg::PH_STATUS) ? w_st : c_dp.cur_status;
    assign w_d1_single  = (w_d1_status[7:4] == mtep_pkg::HI_PROGRAM) ||
                          (w_d1_status[7:4] == mtep_pkg::HI_CHAN_PRESS);

    // Size, tempo and skip arithmetic
    assign w_len_next   = mtep_pkg::add_length(c_dp.length, w_b);
    assign w_tempo_val  = {c_dp.value[mtep_pkg::VALUE_W-mtep_pkg::BYTE_W-1:0], w_b};
    assign w_tempo_last = (c_dp.count >= mtep_pkg::TEMPO_LAST);
    assign w_surplus    = (c_dp.length > mtep_pkg::TEMPO_BYTES);
    assign w_skip_done  = (c_dp.skip <= mtep_pkg::LEN_W'(1));

    // Delta accumulation with saturation
    assign w_delta_sat  = |c_delta[DELTA_BITS-1 -: mtep_pkg::DATA_W];
    assign w_delta_next = w_delta_sat ? '1 : ((c_delta << mtep_pkg::DATA_W) | DELTA_BITS'(w_d));

    // Next phase
    always_comb begin
        n_phase = c_phase;
        unique case (c_phase)
            mtep_pkg::PH_DELTA: begin
                n_phase = w_msb ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
            end
            mtep_pkg::PH_STATUS: begin
                if (w_no_running) begin
                    n_phase = mtep_pkg::PH_DONE;
                end else if (w_st_meta) begin
                    n_phase = w_msb ? mtep_pkg::PH_META_TYPE : mtep_pkg::PH_META_LEN;
                end else if (w_st_sysex) begin
                    n_phase = mtep_pkg::PH_SYSEX_LEN;
                end else if (w_st_chan) begin
                    if (w_msb) begin
                        n_phase = mtep_pkg::PH_DATA1;
                    end else begin
                        n_phase = w_d1_single ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
                    end
                end else begin
                    n_phase = w_msb ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_DATA1: begin
                n_phase = w_d1_single ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
            end
            mtep_pkg::PH_DATA2: begin
                n_phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_META_TYPE: begin
                n_phase = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN: begin
                if (!w_msb) begin
                    if (c_dp.meta_type == mtep_pkg::META_EOT) begin
                        n_phase = mtep_pkg::PH_DONE;
                    end else if (c_dp.meta_type == mtep_pkg::META_TEMPO) begin
                        n_phase = mtep_pkg::PH_TEMPO;
                    end else begin
                        n_phase = (w_len_next == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
                    end
                end
            end
            mtep_pkg::PH_TEMPO: begin
                if (w_tempo_last) begin
                    n_phase = w_surplus ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_SYSEX_LEN: begin
                if (!w_msb) begin
                    if (c_dp.cur_status == mtep_pkg::ST_SYSEX) begin
                        n_phase = mtep_pkg::PH_SYSEX_PEEK;
                    end else begin
                        n_phase = (w_len_next == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
                    end
                end
            end
            mtep_pkg::PH_SYSEX_PEEK: begin
                if (w_b == mtep_pkg::ST_ESCAPE) begin
                    n_phase = (c_dp.length == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
                end else if (c_dp.length == '0) begin
                    // byte opens the next delta time
                    n_phase = w_msb ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
                end else begin
                    // byte is the first payload byte
                    n_phase = (c_dp.length == mtep_pkg::LEN_W'(1)) ? mtep_pkg::PH_DELTA
                                                                    : mtep_pkg::PH_SKIP;
                end
            end
            mtep_pkg::PH_SKIP: begin
                n_phase = w_skip_done ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
            end
            mtep_pkg::PH_DONE: begin
                n_phase = mtep_pkg::PH_DONE;
            end
            default: begin
                n_phase = mtep_pkg::PH_DELTA;
            end
        endcase
    end

    // Datapath update and event word
    always_comb begin
        n_dp      = c_dp;
        n_delta   = c_delta;
        n_clamped = c_clamped;
        w_emit    = 1'b0;
        w_event.event_kind      = mtep_pkg::KIND_NOTE_OFF;
        w_event.channel         = '0;
        w_event.key_or_number   = '0;
        w_event.event_value     = '0;
        w_event.delta_ticks     = mtep_pkg::TICKS_W'(c_delta);
        w_event.delta_saturated = c_clamped;

        // Restart the delta on every return to the delta phase
        if ((n_phase == mtep_pkg::PH_DELTA) && (c_phase != mtep_pkg::PH_DELTA)) begin
            n_delta   = '0;
            n_clamped = 1'b0;
        end

        case (c_phase)
            mtep_pkg::PH_DELTA: begin
                n_delta   = w_delta_next;
                n_clamped = c_clamped | w_delta_sat;
            end
            mtep_pkg::PH_STATUS: begin
                if (w_no_running) begin
                    w_emit = 1'b1;
                    w_event.event_kind = mtep_pkg::KIND_NO_RUNNING;
                end else begin
                    if (w_msb && !w_st_sysex) begin
                        n_dp.running = w_b;
                    end
                    n_dp.cur_status = w_st;
                    if (w_st_meta) begin
                        if (!w_msb) begin
                            n_dp.meta_type = w_b;
                            n_dp.length    = '0;
                        end
                    end else if (w_st_sysex) begin
                        n_dp.length = '0;
                    end else if (w_st_chan) begin
                        if (!w_msb) begin
                            n_dp.first = w_d;
                            if (w_d1_single) begin
                                w_emit = 1'b1;
                            end
                        end
                    end else begin
                        w_emit = 1'b1;
                        w_event.event_kind = mtep_pkg::KIND_UNSUPPORTED;
                        n_delta   = w_msb ? '0 : DELTA_BITS'(w_d);
                        n_clamped = 1'b0;
                    end
                end
            end
            mtep_pkg::PH_DATA1: begin
                n_dp.first = w_d;
                if (w_d1_single) begin
                    w_emit = 1'b1;
                end
            end
            mtep_pkg::PH_DATA2: begin
                w_emit = 1'b1;
                w_event.channel       = c_dp.cur_status[3:0];
                w_event.key_or_number = c_dp.first;
                w_event.event_value   = mtep_pkg::VALUE_W'(w_d);
                case (c_dp.cur_status[7:4])
                    mtep_pkg::HI_NOTE_OFF:  w_event.event_kind = mtep_pkg::KIND_NOTE_OFF;
                    mtep_pkg::HI_NOTE_ON:   w_event.event_kind = (w_d == '0) ?
                                                mtep_pkg::KIND_NOTE_OFF : mtep_pkg::KIND_NOTE_ON;
                    mtep_pkg::HI_KEY_PRESS: w_event.event_kind = mtep_pkg::KIND_KEY_PRESS;
                    mtep_pkg::HI_CONTROL:   w_event.event_kind = mtep_pkg::KIND_CONTROL;
                    default: begin
                        w_event.event_kind    = mtep_pkg::KIND_BEND;
                        w_event.key_or_number = '0;
                        w_event.event_value   = mtep_pkg::VALUE_W'({w_d, c_dp.first});
                    end
                endcase
            end
            mtep_pkg::PH_META_TYPE: begin
                n_dp.meta_type = w_b;
                n_dp.length    = '0;
            end
            mtep_pkg::PH_META_LEN: begin
                n_dp.length = w_len_next;
                if (!w_msb) begin
                    if (c_dp.meta_type == mtep_pkg::META_EOT) begin
                        w_emit = 1'b1;
                        w_event.event_kind = mtep_pkg::KIND_END;
                    end else if (c_dp.meta_type == mtep_pkg::META_TEMPO) begin
                        n_dp.count = '0;
                        n_dp.value = '0;
                    end else begin
                        n_dp.skip = (w_len_next == '0) ? c_dp.skip : w_len_next;
                    end
                end
            end
            mtep_pkg::PH_TEMPO: begin
                n_dp.value = w_tempo_val;
                if (!w_tempo_last) begin
                    n_dp.count = c_dp.count + mtep_pkg::COUNT_W'(1);
                end else begin
                    n_dp.count = '0;
                    w_emit = 1'b1;
                    w_event.event_kind  = mtep_pkg::KIND_TEMPO;
                    w_event.event_value = w_tempo_val;
                    if (w_surplus) begin
                        n_dp.skip = c_dp.length - mtep_pkg::TEMPO_BYTES;
                    end
                end
            end
            mtep_pkg::PH_SYSEX_LEN: begin
                n_dp.length = w_len_next;
                if (!w_msb && (c_dp.cur_status != mtep_pkg::ST_SYSEX) && (w_len_next != '0)) begin
                    n_dp.skip = w_len_next;
                end
            end
            mtep_pkg::PH_SYSEX_PEEK: begin
                if (w_b == mtep_pkg::ST_ESCAPE) begin
                    if (c_dp.length != '0) begin
                        n_dp.skip = c_dp.length;
                    end
                end else if (c_dp.length == '0) begin
                    n_delta   = DELTA_BITS'(w_d);
                    n_clamped = 1'b0;
                end else begin
                    n_dp.skip = c_dp.length - mtep_pkg::LEN_W'(1);
                end
            end
            mtep_pkg::PH_SKIP: begin
                n_dp.skip = (c_dp.skip == '0) ? '0 : (c_dp.skip - mtep_pkg::LEN_W'(1));
            end
            default: begin
                n_dp = c_dp;
            end
        endcase

        // Program and channel pressure take their fields from the first data byte
        if (w_emit && ((c_phase == mtep_pkg::PH_DATA1) ||
                       ((c_phase == mtep_pkg::PH_STATUS) && !w_no_running && w_st_chan &&
                        !w_st_meta && !w_st_sysex))) begin
            w_event.event_kind  = (w_d1_status[7:4] == mtep_pkg::HI_PROGRAM) ?
                                  mtep_pkg::KIND_PROGRAM : mtep_pkg::KIND_CHAN_PRESS;
            w_event.channel     = w_d1_status[3:0];
            w_event.event_value = mtep_pkg::VALUE_W'(w_d);
        end
    end

    // Advance parser state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::PH_DELTA;
            r_dp      <= mtep_pkg::PARSE_RESET;
            r_delta   <= '0;
            r_clamped <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_dp      <= n_dp;
            r_delta   <= n_delta;
            r_clamped <= n_clamped;
        end
    end

    assign o_emit  = w_emit;
    assign o_event = w_event;

    // A finished track yields nothing until the next track start
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_phase == mtep_pkg::PH_DONE) && !i_word.track_start) |-> !w_emit)
        else $error("event produced after end of track");

    // End of track or a missing running status parks the parser
    a_end_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_emit && ((w_event.event_kind == mtep_pkg::KIND_END) ||
                              (w_event.event_kind == mtep_pkg::KIND_NO_RUNNING)))
        |=> (r_phase == mtep_pkg::PH_DONE))
        else $error("parser not parked after final event");

    // The skip phase always has bytes left to drop
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_SKIP) |-> (r_dp.skip != '0))
        else $error("skip phase with empty count");

    // Tempo byte count stays within three bytes
    a_tempo_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dp.count <= mtep_pkg::TEMPO_LAST))
        else $error("tempo byte count overrun");

endmodule
`default_nettype wire

@@ design/mtep_out_stage.sv @@
`default_nettype none
// ============================================================================
// mtep_out_stage: result register
// Holds one event word until the downstream side takes it.
// ============================================================================
module mtep_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire mtep_pkg::t_event i_event,
    output logic                  o_free,
    mtep_event_if.source          o_event
);

    logic             r_valid;
    mtep_pkg::t_event r_event;

    // Free when empty or emptied this cycle
    assign o_free = !r_valid || o_event.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event <= i_event;
        end
    end

    assign o_event.valid           = r_valid;
    assign o_event.event_kind      = r_event.event_kind;
    assign o_event.channel         = r_event.channel;
    assign o_event.key_or_number   = r_event.key_or_number;
    assign o_event.event_value     = r_event.event_value;
    assign o_event.delta_ticks     = r_event.delta_ticks;
    assign o_event.delta_saturated = r_event.delta_saturated;

endmodule
`default_nettype wire

@@ design/midi_track_event_parser.sv @@
// Path: an accepted byte is held in the input register, decoded by the parser, and
//   its event word is loaded into the result register.
// Throughput: one byte per cycle unless stalled; the parser updates once per byte.
// A stalled output holds one result and one more byte in the input register.
// Reset: synchronous active-low i_rst_n clears the parser to the delta phase and
//   empties both registers; no clearing pass.
`default_nettype none
// ============================================================================
// midi_track_event_parser: MIDI file track event parser, top level
// Input register, byte parser and result register in a single pass.
// ============================================================================
module midi_track_event_parser #(
    parameter int DELTA_BITS = mtep_pkg::DELTA_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mtep_byte_if.sink    i_byte,
    mtep_event_if.source o_event
);

    logic                 w_in_valid;
    mtep_pkg::t_byte_word w_word;
    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_emit;
    mtep_pkg::t_event     w_event;

    // Consume the held byte when the result register can take its word
    assign w_fire = w_in_valid && w_out_free;

    mtep_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_word  (w_word)
    );

    mtep_parser #(
        .DELTA_BITS (DELTA_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_word  (w_word),
        .o_emit  (w_emit),
        .o_event (w_event)
    );

    mtep_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_emit),
        .i_event (w_event),
        .o_free  (w_out_free),
        .o_event (o_event)
    );

endmodule
`default_nettype wire

@@ bench/midi_track_event_parser_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// midi_track_event_parser_tb: self-checking bench of the MIDI track parser
// Feeds track bodies byte by byte (a short fixed opening, then random tracks
// built from channel, meta, sysex and unsupported events with noise), keeps
// its own model of the parser to predict every event word, and compares the
// words leaving the block field by field under random source and sink idling.
// ============================================================================
module midi_track_event_parser_tb;
    import mtep_pkg::*;

    // Status byte ranges and a plain text meta type
    localparam logic [7:0] CHAN_FIRST = 8'h80;
    localparam logic [7:0] CHAN_LAST  = 8'hEF;
    localparam logic [7:0] SYS_FIRST  = 8'hF1;
    localparam logic [7:0] SYS_LAST   = 8'hFE;
    localparam logic [7:0] META_TEXT  = 8'h01;
    localparam logic [7:0] SIZE_MORE  = 8'h80;

    localparam logic [TICKS_W-1:0] DELTA_FULL = '1;
    localparam logic [LEN_W-1:0]   SIZE_FULL  = '1;

    localparam int RANDOM_BYTES    = 1100;
    localparam int SECOND_TRACK_AT = 24;

    // Opening: max delta with note-on velocity 0, saturated delta with running
    // note-on and masked data, unsupported status and its running reuse,
    // tempo, then a new track whose first status is a bare data byte.
    localparam logic [7:0] OPENING [26] = '{
        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h3C, 8'h00,
        8'h81, 8'h80, 8'h80, 8'h80, 8'h00, 8'h7F, 8'hFF,
        8'h00, 8'hF3, 8'h00, 8'h05,
        8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
        8'h00, 8'h40
    };

    // Track parser model and store of awaited event words
    class track_event_checker;
        t_phase             phase;
        logic [7:0]         running_st;
        logic [7:0]         cur_st;
        logic [7:0]         meta_code;
        logic [TICKS_W-1:0] delta_acc;
        logic               delta_sat;
        logic [LEN_W-1:0]   size_acc;
        logic [LEN_W-1:0]   skip_left;
        logic [6:0]         first_data;
        logic [VALUE_W-1:0] tempo_acc;
        logic [COUNT_W-1:0] tempo_count;
        bit                 halted;
        t_event             awaited_events[$];
        int                 mismatch_count;

        function new();
            clear_state();
            mismatch_count = 0;
        endfunction

        function void clear_state();
            phase       = PH_DELTA;
            running_st  = '0;
            cur_st      = '0;
            meta_code   = '0;
            delta_acc   = '0;
            delta_sat   = 1'b0;
            size_acc    = '0;
            skip_left   = '0;
            first_data  = '0;
            tempo_acc   = '0;
            tempo_count = '0;
            halted      = 1'b0;
        endfunction

        function void restart_delta();
            phase     = PH_DELTA;
            delta_acc = '0;
            delta_sat = 1'b0;
        endfunction

        function void start_skip(input logic [LEN_W-1:0] n);
            if (n == '0) begin
                restart_delta();
            end else begin
                skip_left = n;
                phase     = PH_SKIP;
            end
        endfunction

        // Size fields clamp at all ones once they would overflow
        function logic [LEN_W-1:0] grow_size(input logic [LEN_W-1:0] len,
                                             input logic [7:0] b);
            if (len > (SIZE_FULL >> 7)) begin
                return SIZE_FULL;
            end
            return (len << 7) | LEN_W'(b[6:0]);
        endfunction

        function void add_event(input t_kind k, input logic [3:0] ch,
                                input logic [6:0] key, input logic [23:0] val);
            t_event ev;
            ev.event_kind      = k;
            ev.channel         = ch;
            ev.key_or_number   = key;
            ev.event_value     = val;
            ev.delta_ticks     = delta_acc;
            ev.delta_saturated = delta_sat;
            awaited_events.insert(awaited_events.size(), ev);
        endfunction

        // Advance the model by one accepted byte
        function void take_byte(input logic [7:0] b, input logic start);
            logic [7:0] st;
            logic [6:0] v;
            t_kind      k;
            bit         again;
            bit         via_running;
            if (start) begin
                clear_state();
            end
            if (halted) begin
                return;
            end
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (phase)
                    PH_DELTA: begin
                        if (delta_acc > (DELTA_FULL >> 7)) begin
                            delta_acc = DELTA_FULL;
                            delta_sat = 1'b1;
                        end else begin
                            delta_acc = (delta_acc << 7) | TICKS_W'(b[6:0]);
                        end
                        if (!b[7]) begin
                            phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        if (!b[7]) begin
                            if (running_st == '0) begin
                                add_event(KIND_NO_RUNNING, '0, '0, '0);
                                halted = 1'b1;
                                return;
                            end
                            st          = running_st;
                            via_running = 1'b1;
                        end else begin
                            st          = b;
                            via_running = 1'b0;
                            if (st != ST_SYSEX && st != ST_ESCAPE) begin
                                running_st = st;
                            end
                        end
                        cur_st = st;
                        if (st == ST_META) begin
                            phase = PH_META_TYPE;
                        end else if (st == ST_SYSEX || st == ST_ESCAPE) begin
                            size_acc = '0;
                            phase    = PH_SYSEX_LEN;
                        end else if (st[7:4] != HI_SYSTEM) begin
                            phase = PH_DATA1;
                        end else begin
                            add_event(KIND_UNSUPPORTED, '0, '0, '0);
                            restart_delta();
                        end
                        // a reused status leaves the byte to the next phase
                        again = via_running;
                    end
                    PH_DATA1: begin
                        first_data = b[6:0];
                        if (cur_st[7:4] == HI_PROGRAM) begin
                            add_event(KIND_PROGRAM, cur_st[3:0], '0, 24'(first_data));
                            restart_delta();
                        end else if (cur_st[7:4] == HI_CHAN_PRESS) begin
                            add_event(KIND_CHAN_PRESS, cur_st[3:0], '0, 24'(first_data));
                            restart_delta();
                        end else begin
                            phase = PH_DATA2;
                        end
                    end
                    PH_DATA2: begin
                        v = b[6:0];
                        case (cur_st[7:4])
                            HI_NOTE_OFF:  k = KIND_NOTE_OFF;
                            HI_NOTE_ON:   k = (v == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                            HI_KEY_PRESS: k = KIND_KEY_PRESS;
                            HI_CONTROL:   k = KIND_CONTROL;
                            default:      k = KIND_BEND;
                        endcase
                        if (k == KIND_BEND) begin
                            add_event(k, cur_st[3:0], '0, 24'({v, first_data}));
                        end else begin
                            add_event(k, cur_st[3:0], first_data, 24'(v));
                        end
                        restart_delta();
                    end
                    PH_META_TYPE: begin
                        meta_code = b;
                        size_acc  = '0;
                        phase     = PH_META_LEN;
                    end
                    PH_META_LEN: begin
                        size_acc = grow_size(size_acc, b);
                        if (!b[7]) begin
                            if (meta_code == META_EOT) begin
                                add_event(KIND_END, '0, '0, '0);
                                halted = 1'b1;
                            end else if (meta_code == META_TEMPO) begin
                                tempo_count = '0;
                                tempo_acc   = '0;
                                phase       = PH_TEMPO;
                            end else begin
                                start_skip(size_acc);
                            end
                        end
                    end
                    PH_TEMPO: begin
                        // always three bytes, surplus skipped afterwards
                        tempo_acc = {tempo_acc[15:0], b};
                        if (tempo_count < TEMPO_LAST) begin
                            tempo_count++;
                        end else begin
                            tempo_count = '0;
                            add_event(KIND_TEMPO, '0, '0, tempo_acc);
                            restart_delta();
                            start_skip((size_acc > TEMPO_BYTES) ? size_acc - TEMPO_BYTES : '0);
                        end
                    end
                    PH_SYSEX_LEN: begin
                        size_acc = grow_size(size_acc, b);
                        if (!b[7]) begin
                            if (cur_st == ST_SYSEX) begin
                                phase = PH_SYSEX_PEEK;
                            end else begin
                                start_skip(size_acc);
                            end
                        end
                    end
                    PH_SYSEX_PEEK: begin
                        // drop an escape byte right after the size
                        start_skip(size_acc);
                        again = (b != ST_ESCAPE);
                    end
                    PH_SKIP: begin
                        if (skip_left != '0) begin
                            skip_left--;
                        end
                        if (skip_left == '0) begin
                            restart_delta();
                        end
                    end
                    default: begin
                        restart_delta();
                        again = 1'b1;
                    end
                endcase
            end
        endfunction

        // Compare one delivered event word with the oldest awaited one
        function void match_event(input t_event seen);
            t_event want;
            bit     bad;
            if (awaited_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected event: kind=%0d ch=%0d key=%0d value=%0h ticks=%0h sat=%0b",
                             seen.event_kind, seen.channel, seen.key_or_number,
                             seen.event_value, seen.delta_ticks, seen.delta_saturated);
                end
                return;
            end
            want = awaited_events.pop_front();
            bad = (seen.event_kind !== want.event_kind)
               || (seen.channel !== want.channel)
               || (seen.key_or_number !== want.key_or_number)
               || (seen.event_value !== want.event_value)
               || (seen.delta_ticks !== want.delta_ticks)
               || (seen.delta_saturated !== want.delta_saturated);
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("event mismatch at %0t:", $realtime);
                    $display("  expected kind=%0d ch=%0d key=%0d value=%0h ticks=%0h sat=%0b",
                             want.event_kind, want.channel, want.key_or_number,
                             want.event_value, want.delta_ticks, want.delta_saturated);
                    $display("  actual   kind=%0d ch=%0d key=%0d value=%0h ticks=%0h sat=%0b",
                             seen.event_kind, seen.channel, seen.key_or_number,
                             seen.event_value, seen.delta_ticks, seen.delta_saturated);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mtep_byte_if  byte_ch ();
    mtep_event_if event_ch ();

    midi_track_event_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_event (event_ch)
    );

    track_event_checker sb;

    int         gap_pct   = 0;
    int         stall_pct = 0;
    t_byte_word track_bytes[$];
    bit         mark_start;
    bit         skip_delta;
    logic [7:0] gen_running;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sink side: stall at random
    always @(posedge i_clk) begin
        event_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Note accepted bytes and check accepted event words
    always @(posedge i_clk) begin : watch
        t_event seen;
        if (i_rst_n) begin
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
                sb.take_byte(byte_ch.data_byte, byte_ch.track_start);
            end
            if (event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
                seen.event_kind      = t_kind'(event_ch.event_kind);
                seen.channel         = event_ch.channel;
                seen.key_or_number   = event_ch.key_or_number;
                seen.event_value     = event_ch.event_value;
                seen.delta_ticks     = event_ch.delta_ticks;
                seen.delta_saturated = event_ch.delta_saturated;
                sb.match_event(seen);
            end
        end
    end

    // ---- stream building -------------------------------------------------

    function automatic void put_byte(input logic [7:0] b);
        t_byte_word w;
        w.data_byte   = b;
        w.track_start = mark_start;
        track_bytes.insert(track_bytes.size(), w);
        mark_start = 1'b0;
    endfunction

    // Data byte biased toward its extremes
    function automatic logic [7:0] data7();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 8'h00;
        end
        if (r == 1) begin
            return 8'h7F;
        end
        return 8'($urandom_range(127));
    endfunction

    // Delta of one to six bytes; five or more usually saturate
    function automatic void put_delta();
        int         n;
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 60) begin
            n = 1;
        end else if (pick < 85) begin
            n = $urandom_range(4, 2);
        end else begin
            n = $urandom_range(6, 5);
        end
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(127));
            if (i != n - 1) begin
                b[7] = 1'b1;
            end
            put_byte(b);
        end
    endfunction

    function automatic void lead_delta();
        if (!skip_delta) begin
            put_delta();
        end
        skip_delta = 1'b0;
    endfunction

    // Small size, sometimes with a redundant leading zero group
    function automatic void put_size(input int len);
        if ($urandom_range(5) == 0) begin
            put_byte(SIZE_MORE);
        end
        put_byte(8'(len));
    endfunction

    function automatic void gen_channel();
        logic [7:0] st;
        logic [7:0] d;
        bit         reuse;
        reuse = (gen_running >= CHAN_FIRST && gen_running <= CHAN_LAST)
             && ($urandom_range(99) < 40);
        if (reuse) begin
            st = gen_running;
        end else begin
            st = 8'($urandom_range(CHAN_LAST, CHAN_FIRST));
            gen_running = st;
            put_byte(st);
        end
        d = data7();
        if (!reuse && $urandom_range(9) == 0) begin
            d[7] = 1'b1;
        end
        put_byte(d);
        if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHAN_PRESS) begin
            d = data7();
            if (st[7:4] == HI_NOTE_ON && $urandom_range(3) == 0) begin
                d = 8'h00;
            end
            if ($urandom_range(9) == 0) begin
                d[7] = 1'b1;
            end
            put_byte(d);
        end
    endfunction

    function automatic void gen_meta();
        logic [7:0] code;
        int         len;
        int         pay;
        bit         reuse;
        reuse = (gen_running == ST_META) && ($urandom_range(99) < 30);
        if (!reuse) begin
            put_byte(ST_META);
            gen_running = ST_META;
        end
        if ($urandom_range(99) < 35) begin
            code = META_TEMPO;
        end else begin
            code = 8'($urandom_range(255));
            if (reuse) begin
                code[7] = 1'b0;
            end
            if (code == META_EOT || code == META_TEMPO) begin
                code = META_TEXT;
            end
        end
        put_byte(code);
        if (code == META_TEMPO) begin
            len = ($urandom_range(99) < 70) ? 3 : $urandom_range(6);
            pay = (len > 3) ? len : 3;
        end else begin
            len = $urandom_range(6);
            pay = len;
        end
        put_size(len);
        repeat (pay) put_byte(8'($urandom_range(255)));
    endfunction

    function automatic void gen_sysex();
        logic [7:0] st;
        logic [7:0] b;
        int         len;
        st  = ($urandom_range(1) == 1) ? ST_SYSEX : ST_ESCAPE;
        len = $urandom_range(6);
        put_byte(st);
        put_size(len);
        if (st == ST_SYSEX && $urandom_range(99) < 40) begin
            put_byte(ST_ESCAPE);
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (i == 0 && b == ST_ESCAPE) begin
                b = 8'h00;
            end
            put_byte(b);
        end
    endfunction

    function automatic void gen_unsupported();
        logic [7:0] st;
        st = 8'($urandom_range(SYS_LAST, SYS_FIRST));
        if (st == ST_ESCAPE) begin
            st = SYS_FIRST;
        end
        put_byte(st);
        gen_running = st;
    endfunction

    function automatic void build_track();
        int n;
        int pick;
        mark_start  = 1'b1;
        gen_running = '0;
        skip_delta  = 1'b0;
        n = $urandom_range(14, 2);
        // occasionally open with a bare data byte where a status belongs
        if ($urandom_range(19) == 0) begin
            put_delta();
            put_byte(data7());
            n = 0;
        end
        for (int i = 0; i < n; i++) begin
            lead_delta();
            pick = $urandom_range(99);
            if (gen_running >= SYS_FIRST && gen_running <= SYS_LAST && pick < 50) begin
                // reused unsupported status: the data byte is the next delta
                put_byte(data7());
                skip_delta = 1'b1;
            end else if (pick < 50) begin
                gen_channel();
            end else if (pick < 72) begin
                gen_meta();
            end else if (pick < 84) begin
                gen_sysex();
            end else if (pick < 94) begin
                gen_unsupported();
            end else if (pick < 97) begin
                repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range(255)));
            end else begin
                gen_channel();
            end
        end
        if (n > 0 && $urandom_range(99) < 85) begin
            lead_delta();
            if (gen_running != ST_META || $urandom_range(1) == 0) begin
                put_byte(ST_META);
            end
            put_byte(META_EOT);
            if ($urandom_range(4) == 0) begin
                // oversized length, clamps and is ignored
                repeat (4) put_byte(8'hFF);
                put_byte(8'h7F);
            end else begin
                put_size($urandom_range(2));
            end
        end
        repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
    endfunction

    // ---- driving ---------------------------------------------------------

    task automatic send_word(input t_byte_word w);
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= w.data_byte;
        byte_ch.track_start <= w.track_start;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        while ($urandom_range(99) < gap_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid for one cycle after the last word of a stream
    task automatic send_stream();
        foreach (track_bytes[i]) begin
            send_word(track_bytes[i]);
        end
        byte_ch.valid <= 1'b0;
        track_bytes.delete();
        @(posedge i_clk);
    endtask

    // Hold the source until every awaited word has left the block
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.awaited_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int sent;
        int track_no;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.track_start = 1'b0;
        event_ch.ready      = 1'b0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening sequence without idling
        foreach (OPENING[i]) begin
            if (i == 0 || i == SECOND_TRACK_AT) begin
                mark_start = 1'b1;
            end
            put_byte(OPENING[i]);
        end
        send_stream();
        wait_drained();

        // Random tracks, idling mode changing every two tracks
        sent     = 0;
        track_no = 0;
        while (sent < RANDOM_BYTES) begin
            case ((track_no / 2) % 5)
                1:       begin gap_pct = 56; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 56; end
                3:       begin gap_pct = 24; stall_pct = 24; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            build_track();
            sent += track_bytes.size();
            send_stream();
            if (track_no % 6 == 5) begin
                wait_drained();
            end
            track_no++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.awaited_events.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ midi_track_event_parser.f @@
design/mtep_pkg.sv
design/mtep_if.sv
design/mtep_in_stage.sv
design/mtep_parser.sv
design/mtep_out_stage.sv
design/midi_track_event_parser.sv
bench/midi_track_event_parser_tb.sv
